// ===== hw/rtl/fdc_pkg.sv =====
package fdc_pkg;

	// disk geometry
	localparam int SECTOR_BYTES      = 137;
	localparam int SECTORS_PER_TRACK = 32;
	localparam int TRACK_BYTES       = SECTOR_BYTES * SECTORS_PER_TRACK;

	localparam int POS_W  = 21;
	localparam int TPROD_W = 25;   // 8 bit track times up to 17 bit track size
	localparam int SPROD_W = 17;   // 6 bit sector times up to 11 bit sector size

	localparam int NSLOTS = 3;
	localparam logic [1:0] EMPTY_SLOT = 2'd2;

	// bus access kinds
	typedef enum logic [2:0] {
		CMD_SELECT = 3'd0,
		CMD_STATUS = 3'd1,
		CMD_FUNC   = 3'd2,
		CMD_SECTOR = 3'd3,
		CMD_DWRITE = 3'd4,
		CMD_DREAD  = 3'd5
	} cmd_t;

	// storage request kinds
	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_READ  = 2'd1,
		MEM_WRITE = 2'd2
	} mem_op_t;

	// status bits, active low
	localparam logic [7:0] ST_ENWD   = 8'h01;
	localparam logic [7:0] ST_HEAD   = 8'h04;
	localparam logic [7:0] ST_TRACK0 = 8'h40;
	localparam logic [7:0] ST_NRDA   = 8'h80;

	// function byte bit positions
	localparam int FN_STEP_IN     = 0;
	localparam int FN_STEP_OUT    = 1;
	localparam int FN_HEAD_LOAD   = 2;
	localparam int FN_HEAD_UNLOAD = 3;
	localparam int FN_WRITE_EN    = 7;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data;
	} fdc_item_t;

	typedef struct packed {
		logic [7:0]       rdata;
		logic [1:0]       op;
		logic             drive;
		logic [POS_W-1:0] addr;
		logic [7:0]       wdata;
	} fdc_res_t;

	function automatic logic [POS_W-1:0] track_start(input logic [7:0] trk);
		logic [TPROD_W-1:0] p;
		p = TPROD_W'(trk) * TPROD_W'(TRACK_BYTES);
		return p[POS_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/fdc_in_stage.sv =====
module fdc_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic [2:0]        s_tuser,
	input  logic              advance,
	output logic              valid_s1,
	output fdc_pkg::fdc_item_t item_s1
);
	import fdc_pkg::*;

	// stage takes a new item when empty or when its item moves on
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd  <= s_tuser;
			item_s1.data <= s_tdata;
		end
	end

endmodule

// ===== hw/rtl/fdc_core.sv =====
module fdc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  fdc_pkg::fdc_item_t item,
	output fdc_pkg::fdc_res_t  res
);
	import fdc_pkg::*;

	logic [1:0]       sel_q;
	logic [7:0]       status_q [NSLOTS];
	logic [7:0]       track_q  [NSLOTS];
	logic [5:0]       sector_q [NSLOTS];
	logic [7:0]       wcount_q [NSLOTS];
	logic [POS_W-1:0] pos_q    [NSLOTS];

	logic [1:0]       s;
	logic [7:0]       st_cur, trk_cur, wc_cur;
	logic [5:0]       sc_cur;
	logic [POS_W-1:0] pos_cur;

	logic [7:0]       trk_step;
	logic [7:0]       st_step;
	logic [7:0]       mul_trk;
	logic [POS_W-1:0] tstart;
	logic [5:0]       sc_wrap;
	logic [SPROD_W-1:0] sec_off;

	logic [1:0]       sel_n;
	logic [7:0]       st_n, trk_n, wc_n;
	logic [5:0]       sc_n;
	logic [POS_W-1:0] pos_n;

	assign s       = (sel_q == 2'd3) ? EMPTY_SLOT : sel_q;
	assign st_cur  = status_q[s];
	assign trk_cur = track_q[s];
	assign sc_cur  = sector_q[s];
	assign wc_cur  = wcount_q[s];
	assign pos_cur = pos_q[s];

	// step in then step out, track saturates at both ends
	always_comb begin
		trk_step = trk_cur;
		st_step  = st_cur;
		if (item.data[FN_STEP_IN]) begin
			if (trk_step != 8'hFF)
				trk_step = trk_step + 8'd1;
			if (trk_step != 8'd0)
				st_step = st_step | ST_TRACK0;
		end
		if (item.data[FN_STEP_OUT]) begin
			if (trk_step != 8'd0)
				trk_step = trk_step - 8'd1;
			if (trk_step == 8'd0)
				st_step = st_step & ~ST_TRACK0;
		end
	end

	// one shared track-start multiply
	assign mul_trk = (item.cmd == CMD_FUNC) ? trk_step : trk_cur;
	assign tstart  = track_start(mul_trk);

	assign sc_wrap = ({1'b0, sc_cur} >= 7'(SECTORS_PER_TRACK)) ? 6'd0 : sc_cur;
	assign sec_off = SPROD_W'(sc_wrap) * SPROD_W'(SECTOR_BYTES);

	always_comb begin
		sel_n = sel_q;
		st_n  = st_cur;
		trk_n = trk_cur;
		sc_n  = sc_cur;
		wc_n  = wc_cur;
		pos_n = pos_cur;
		res   = '0;
		case (item.cmd)
			CMD_SELECT: begin
				case (item.data[3:0])
					4'd0:    sel_n = 2'd0;
					4'd1:    sel_n = 2'd1;
					default: sel_n = EMPTY_SLOT;
				endcase
			end
			CMD_STATUS: begin
				res.rdata = st_cur;
			end
			CMD_FUNC: begin
				st_n  = st_step;
				trk_n = trk_step;
				if (item.data[FN_STEP_IN] || item.data[FN_STEP_OUT])
					pos_n = tstart;
				if (item.data[FN_HEAD_LOAD])
					st_n = st_n & ~(ST_HEAD | ST_NRDA);
				if (item.data[FN_HEAD_UNLOAD])
					st_n = st_n | ST_HEAD;
				if (item.data[FN_WRITE_EN]) begin
					st_n = st_n & ~ST_ENWD;
					wc_n = 8'd0;
				end
			end
			CMD_SECTOR: begin
				pos_n     = tstart + POS_W'(sec_off);
				res.rdata = {1'b0, sc_wrap, 1'b0};
				sc_n      = sc_wrap + 6'd1;
			end
			CMD_DWRITE: begin
				if (s != EMPTY_SLOT) begin
					res.op    = MEM_WRITE;
					res.drive = s[0];
					res.addr  = pos_cur;
					res.wdata = item.data;
				end
				pos_n = pos_cur + POS_W'(1);
				if ({3'b0, wc_cur} == 11'(SECTOR_BYTES)) begin
					wc_n = 8'd0;
					st_n = st_cur | ST_ENWD;
				end else begin
					wc_n = wc_cur + 8'd1;
				end
			end
			CMD_DREAD: begin
				if (s != EMPTY_SLOT) begin
					res.op    = MEM_READ;
					res.drive = s[0];
					res.addr  = pos_cur;
				end
				pos_n = pos_cur + POS_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= EMPTY_SLOT;
			for (int i = 0; i < NSLOTS; i++) begin
				status_q[i] <= 8'hFF;
				track_q[i]  <= 8'd0;
				sector_q[i] <= 6'd0;
				wcount_q[i] <= 8'd0;
				pos_q[i]    <= '0;
			end
		end else if (fire) begin
			sel_q       <= sel_n;
			status_q[s] <= st_n;
			track_q[s]  <= trk_n;
			sector_q[s] <= sc_n;
			wcount_q[s] <= wc_n;
			pos_q[s]    <= pos_n;
		end
	end

endmodule

// ===== hw/rtl/floppy_disk_controller_ports.sv =====
// Port-level model of a hard-sectored floppy controller with two drives and
// an empty third slot. Each input item is one processor bus access (kind on
// s_tuser, byte on s_tdata) and gives exactly one result item: a register read
// byte plus a storage request (none, read byte, write byte) with drive and
// byte address into an outside drive image. Reads of the image data itself
// come back from that outside memory, not through this block. One item is
// accepted per clock unless the result side stalls; an item passes the input
// register and then the result register, with the per-slot update logic (a
// track-start multiply, a sector-offset multiply and an add) between them.
// The result register frees the input side, so one more item is still taken
// while a result waits; after that the input stalls until the result moves.
// After reset the empty slot is selected and all status bits are inactive.
module floppy_disk_controller_ports (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_in
	input  logic [2:0]  s_tuser,   // [2:0] cmd
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] reg_rdata, [8] mem_drive,
	                               // [29:9] mem_addr, [37:30] mem_wdata, rest zero
	output logic [1:0]  m_tuser    // [1:0] mem_op
);
	import fdc_pkg::*;

	logic      valid_s1;
	fdc_item_t item_s1;
	logic      advance;
	logic      fire;
	fdc_res_t  res;
	fdc_res_t  res_q;
	logic      out_valid_q;

	// item in stage 1 moves on when the result register is free or being taken
	assign advance = !out_valid_q || m_tready;
	assign fire    = valid_s1 && advance;

	fdc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// per-slot drive state and the access decode
	fdc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.op;
	assign m_tdata  = {2'b00, res_q.wdata, res_q.addr, res_q.drive, res_q.rdata};

	// no storage request means all request fields are zero
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == MEM_NONE) |-> (m_tdata[37:8] == '0))
		else $error("request fields set without a storage request");

	// a read request carries no write byte
	a_read_wdata: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == MEM_READ) |-> (m_tdata[37:30] == 8'd0))
		else $error("read request with write byte");

	// a held stage-1 item keeps its contents
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stage 1 item lost while stalled");

endmodule
